// File: design/tgc_pkg.sv
// Shared types and constants of the touch gesture classifier.
`default_nettype none

package tgc_pkg;

	// Button count limits and reset values of the timing registers
	localparam int unsigned NUM_BUTTONS = 16;
	localparam logic [15:0] CLICK_WINDOW_RESET = 16'd250;
	localparam logic [15:0] LONG_TOUCH_RESET = 16'd1250;
	localparam logic [15:0] POSITIONING_RESET = 16'd3000;

	// Click counter codes
	localparam logic [7:0] POS_MARK = 8'd255;
	localparam logic [7:0] COUNT_MAX = 8'd254;

	// Input item kinds
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_CHECK = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_CLICK_WINDOW = 3'd0;
	localparam logic [2:0] REG_LONG_TOUCH = 3'd1;
	localparam logic [2:0] REG_POSITIONING = 3'd2;
	localparam logic [2:0] REG_MULTI_CLICK_EN = 3'd3;
	localparam logic [2:0] REG_POSITIONING_EN = 3'd4;

	typedef enum logic [1:0] {
		EV_CLICK,
		EV_LONG,
		EV_POS_START,
		EV_POS_STOP
	} tgc_event_t;

	// One event as it leaves the block, minus the last flag
	typedef struct packed {
		logic [3:0] button;
		tgc_event_t code;
		logic [7:0] count;
	} tgc_ev_t;

	// Scanner to output stage
	typedef struct packed {
		logic push;
		logic flush;
		tgc_ev_t ev;
	} tgc_stage_req_t;

	// Output stage to scanner
	typedef struct packed {
		logic ready;
		logic held;
	} tgc_stage_stat_t;

endpackage

`default_nettype wire

// File: design/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: button scanner and configuration registers.
//
// Turns touch activity on up to BUTTONS buttons into click, multi-click, long touch and
// positioning events. A sample transaction (mode 0) carries the button word and the time;
// a check transaction (mode 1) scans pending buttons against the timing registers. The
// block takes one transaction at a time: in_stall stays high until its last event has
// been handed to the output register. One 32-bit time subtractor is shared by every
// button and visited once per button for a sample and twice per button for a check;
// the scan also waits while the output is stalled and a second event is pending.
// Events come out in button order; the final event of a transaction carries last.
// Configuration writes are accepted every cycle.
`default_nettype none

module touch_gesture_classifier
	import tgc_pkg::*;
#(
	parameter int unsigned BUTTONS = NUM_BUTTONS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input transactions
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [15:0] buttons,
	input  wire logic [31:0] now_ms,
	// events
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       button,
	output logic [1:0]       event_res,
	output logic [7:0]       count,
	output logic             last,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTONS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRESS,
		S_DECIDE,
		S_FLUSH
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0]        click_window_q;
	logic [15:0]        long_touch_q;
	logic [15:0]        positioning_q;
	logic [BUTTONS-1:0] multi_click_en_q;
	logic [BUTTONS-1:0] positioning_en_q;

	// latched transaction
	logic               mode_q;
	logic [BUTTONS-1:0] btn_q;
	logic [31:0]        now_q;

	// per-button state
	logic [BUTTONS-1:0] prev_q;
	logic [31:0]        press_time_q [BUTTONS];
	logic [31:0]        rel_time_q [BUTTONS];
	logic [7:0]         cc_q [BUTTONS];
	logic [BUTTONS-1:0] rv_q;
	logic [BUTTONS-1:0] pend_q;

	logic [IDX_W-1:0]   idx_q;
	logic [31:0]        dp_q;

	// shared time unit and decision
	logic [31:0]        opnd;
	logic [31:0]        diff;
	logic [7:0]         cc_cur;
	logic [7:0]         cc_tmp;
	logic [7:0]         cc_n;
	logic               rv_n;
	logic               pend_n;
	logic               pt_we;
	logic [31:0]        pt_d;
	logic               rt_we;
	logic [31:0]        rt_d;
	logic               ev_fire;
	tgc_ev_t            ev_d;
	logic               adv;

	tgc_stage_req_t     st_req;
	tgc_stage_stat_t    st_stat;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_window_q <= CLICK_WINDOW_RESET;
			long_touch_q <= LONG_TOUCH_RESET;
			positioning_q <= POSITIONING_RESET;
			multi_click_en_q <= '0;
			positioning_en_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLICK_WINDOW: click_window_q <= cfg_data;
				REG_LONG_TOUCH: long_touch_q <= cfg_data;
				REG_POSITIONING: positioning_q <= cfg_data;
				REG_MULTI_CLICK_EN: multi_click_en_q <= cfg_data[BUTTONS-1:0];
				REG_POSITIONING_EN: positioning_en_q <= cfg_data[BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	// Shared subtractor: press age in S_PRESS, release age in S_DECIDE
	assign opnd = (state_q == S_DECIDE) ? rel_time_q[idx_q] : press_time_q[idx_q];
	assign diff = now_q - opnd;
	assign cc_cur = cc_q[idx_q];

	// Per-button decision
	always_comb begin
		cc_tmp = cc_cur;
		cc_n = cc_cur;
		rv_n = rv_q[idx_q];
		pend_n = pend_q[idx_q];
		pt_we = 1'b0;
		pt_d = now_q;
		rt_we = 1'b0;
		rt_d = now_q;
		ev_fire = 1'b0;
		ev_d.button = 4'(idx_q);
		ev_d.code = EV_CLICK;
		ev_d.count = 8'd1;
		if (mode_q == MODE_SAMPLE) begin
			if (btn_q[idx_q] != prev_q[idx_q]) begin
				if (btn_q[idx_q]) begin
					// press: continue a multi-click or start over
					if (rv_q[idx_q] && (diff <= {16'd0, click_window_q})) begin
						cc_n = (cc_cur < COUNT_MAX) ? 8'(cc_cur + 8'd1) : COUNT_MAX;
						rv_n = 1'b0;
					end else begin
						cc_n = 8'd1;
					end
					pt_we = 1'b1;
					pend_n = 1'b1;
				end else begin
					// release: end positioning, or else record the release time of a counted press
					if (cc_cur == POS_MARK) begin
						ev_fire = 1'b1;
						ev_d.code = EV_POS_STOP;
						cc_tmp = 8'd0;
					end
					cc_n = cc_tmp;
					if (cc_tmp != 8'd0) begin
						rt_we = 1'b1;
						rv_n = 1'b1;
						pend_n = 1'b1;
					end
				end
			end
		end else if (pend_q[idx_q]) begin
			if (positioning_en_q[idx_q] && (dp_q >= {16'd0, positioning_q})) begin
				ev_fire = 1'b1;
				ev_d.code = EV_POS_START;
				pt_we = 1'b1;
				pt_d = '0;
				rt_we = 1'b1;
				rt_d = '0;
				rv_n = 1'b0;
				cc_n = POS_MARK;
				pend_n = 1'b0;
			end else if (dp_q >= {16'd0, long_touch_q}) begin
				ev_fire = 1'b1;
				ev_d.code = EV_LONG;
				pt_we = 1'b1;
				pt_d = '0;
				rt_we = 1'b1;
				rt_d = '0;
				rv_n = 1'b0;
				cc_n = 8'd0;
				pend_n = 1'b0;
			end else if (rv_q[idx_q] &&
				((diff >= {16'd0, click_window_q}) || !multi_click_en_q[idx_q])) begin
				ev_fire = 1'b1;
				ev_d.code = EV_CLICK;
				ev_d.count = cc_cur;
				pt_we = 1'b1;
				pt_d = '0;
				rt_we = 1'b1;
				rt_d = '0;
				rv_n = 1'b0;
				cc_n = 8'd0;
				pend_n = 1'b0;
			end
		end
	end

	// A button step completes unless its event must wait for the output stage
	assign adv = (state_q == S_DECIDE) && (!ev_fire || st_stat.ready);

	assign st_req.push = (state_q == S_DECIDE) && ev_fire;
	assign st_req.flush = (state_q == S_FLUSH);
	assign st_req.ev = ev_d;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			prev_q <= '0;
			rv_q <= '0;
			pend_q <= '0;
			for (int i = 0; i < int'(BUTTONS); i++) begin
				cc_q[i] <= 8'd0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						btn_q <= buttons[BUTTONS-1:0];
						now_q <= now_ms;
						idx_q <= '0;
						state_q <= (mode == MODE_CHECK) ? S_PRESS : S_DECIDE;
					end
				end
				S_PRESS: begin
					dp_q <= diff;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (adv) begin
						cc_q[idx_q] <= cc_n;
						rv_q[idx_q] <= rv_n;
						pend_q[idx_q] <= pend_n;
						if (idx_q == LAST_IDX) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= (mode_q == MODE_CHECK) ? S_PRESS : S_DECIDE;
						end
					end
				end
				S_FLUSH: begin
					if (st_stat.ready) begin
						if (mode_q == MODE_SAMPLE) begin
							prev_q <= btn_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Timestamps are only read after being written
	always_ff @(posedge clk) begin
		if (adv && pt_we) begin
			press_time_q[idx_q] <= pt_d;
		end
		if (adv && rt_we) begin
			rel_time_q[idx_q] <= rt_d;
		end
	end

	tgc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (st_req),
		.stat      (st_stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.button    (button),
		.event_res (event_res),
		.count     (count),
		.last      (last)
	);

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("transaction accepted but input not stalled next cycle");

	a_pending_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q[idx_q] || rv_q[idx_q]) |-> (cc_q[idx_q] != 8'd0 && cc_q[idx_q] != POS_MARK))
		else $error("pending or released button without a click count");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !st_stat.held)
		else $error("event left in hold register after transaction end");

endmodule

`default_nettype wire

// File: design/tgc_out_stage.sv
// Output staging: holds the newest event until it is known whether it is the last one.
`default_nettype none

module tgc_out_stage
	import tgc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tgc_stage_req_t  req,
	output tgc_stage_stat_t      stat,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [3:0]           button,
	output logic [1:0]           event_res,
	output logic [7:0]           count,
	output logic                 last
);

	logic    hold_v_q;
	tgc_ev_t hold_q;
	logic    out_valid_q;
	tgc_ev_t out_q;
	logic    last_q;
	logic    out_free;

	// Output register frees up at this edge if empty or being taken
	assign out_free = !out_valid_q || !out_stall;
	assign stat.ready = !hold_v_q || out_free;
	assign stat.held = hold_v_q;

	// Hold and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (req.push && stat.ready) begin
			// a newer event proves the held one is not the last
			if (hold_v_q) begin
				out_q <= hold_q;
				last_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			hold_q <= req.ev;
			hold_v_q <= 1'b1;
		end else if (req.flush && hold_v_q && out_free) begin
			out_q <= hold_q;
			last_q <= 1'b1;
			out_valid_q <= 1'b1;
			hold_v_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign button = out_q.button;
	assign event_res = out_q.code;
	assign count = out_q.count;
	assign last = last_q;

endmodule

`default_nettype wire
